>>> rtl/dbom_pkg.sv
// shared types and constants for the dual board overheat monitor
// depends on nothing; imported by every module of the block

package dbom_pkg;

    // field widths
    localparam int TEMP_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 8;
    localparam int TIMER_W    = 17;
    localparam int ACT_W      = 2;
    localparam int BOTH_W     = 20;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 56;

    // default averaging window
    localparam int AVG_SAMPLES_DEF = 10;

    typedef logic signed [TEMP_W-1:0] temp_t;

    // per board monitoring state
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_WARN   = 2'd1,
        MODE_ALARM  = 2'd2
    } mode_t;

    // per board action code
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 2'd0,
        ACT_ALARM    = 2'd1,
        ACT_SET_WARN = 2'd2,
        ACT_CLR_WARN = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CTRL_WARN   = 8'd0,
        REG_CTRL_ALARM  = 8'd1,
        REG_CTRL_CLEAR  = 8'd2,
        REG_POWER_WARN  = 8'd3,
        REG_POWER_ALARM = 8'd4,
        REG_POWER_CLEAR = 8'd5,
        REG_STARTUP     = 8'd6,
        REG_CONFIRM     = 8'd7
    } cfg_reg_t;

    // thresholds of one board
    typedef struct packed {
        logic signed [TEMP_W-1:0] warn_level;
        logic signed [TEMP_W-1:0] alarm_level;
        logic signed [TEMP_W-1:0] clear_level;
    } board_cfg_t;

    // register reset values
    localparam logic signed [CFG_W-1:0] WARN_LEVEL_RST  = 16'sd900;
    localparam logic signed [CFG_W-1:0] ALARM_LEVEL_RST = 16'sd1000;
    localparam logic signed [CFG_W-1:0] CLEAR_LEVEL_RST = 16'sd850;
    localparam logic [CFG_W-1:0]        STARTUP_RST     = 16'd1000;
    localparam logic [CFG_W-1:0]        CONFIRM_RST     = 16'd10000;

endpackage

>>> rtl/dbom_board.sv
// per board overheat state machine with start-up check and debounce timers
// depends on dbom_pkg

module dbom_board (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step_en,
    input  logic                                  startup_phase,
    input  dbom_pkg::temp_t                       temp,
    input  dbom_pkg::board_cfg_t                  cfg,
    input  logic [dbom_pkg::CFG_W-1:0]            confirm_ticks,
    output dbom_pkg::action_t                     action
);
    import dbom_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [TIMER_W-1:0] warn_timer_reg, warn_timer_next;
    logic [TIMER_W-1:0] alarm_timer_reg, alarm_timer_next;
    logic               warn_due, alarm_due;

    // a timer is due once it has passed the confirm count
    assign warn_due  = warn_timer_reg  > TIMER_W'(confirm_ticks);
    assign alarm_due = alarm_timer_reg > TIMER_W'(confirm_ticks);

    // next state, timers and action
    always_comb begin
        mode_next        = mode_reg;
        warn_timer_next  = warn_timer_reg;
        alarm_timer_next = alarm_timer_reg;
        action           = ACT_NONE;
        if (startup_phase) begin
            // start-up window: only the clear level is watched
            if (temp > cfg.clear_level) begin
                if (alarm_due) begin
                    mode_next = MODE_ALARM;
                    action    = ACT_ALARM;
                end else begin
                    alarm_timer_next = alarm_timer_reg + 1'b1;
                end
            end else begin
                alarm_timer_next = '0;
            end
        end else begin
            case (mode_reg)
                MODE_NORMAL: begin
                    if (temp > cfg.warn_level) begin
                        if (warn_due) begin
                            mode_next = MODE_WARN;
                            action    = ACT_SET_WARN;
                        end else begin
                            warn_timer_next = warn_timer_reg + 1'b1;
                        end
                    end else begin
                        warn_timer_next = '0;
                    end
                end
                MODE_WARN: begin
                    if (temp > cfg.alarm_level) begin
                        if (alarm_due) begin
                            mode_next = MODE_ALARM;
                            action    = ACT_ALARM;
                        end else begin
                            alarm_timer_next = alarm_timer_reg + 1'b1;
                        end
                    end else if (temp < cfg.warn_level) begin
                        mode_next = MODE_NORMAL;
                        action    = ACT_CLR_WARN;
                    end else begin
                        action           = ACT_SET_WARN;
                        alarm_timer_next = '0;
                    end
                end
                MODE_ALARM: begin
                    if (temp > cfg.clear_level) begin
                        action = ACT_ALARM;
                    end else begin
                        mode_next = MODE_NORMAL;
                    end
                end
                default: begin
                    mode_next = MODE_NORMAL;
                end
            endcase
        end
    end

    // state and timer registers, updated once per word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_NORMAL;
            warn_timer_reg  <= '0;
            alarm_timer_reg <= '0;
        end else if (step_en) begin
            mode_reg        <= mode_next;
            warn_timer_reg  <= warn_timer_next;
            alarm_timer_reg <= alarm_timer_next;
        end
    end

endmodule

>>> rtl/dbom_avg.sv
// running sums of both boards and the averaged values every AVG_SAMPLES words
// depends on dbom_pkg

module dbom_avg #(
    parameter int AVG_SAMPLES = dbom_pkg::AVG_SAMPLES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step_en,
    input  dbom_pkg::temp_t                       ctrl_temp,
    input  dbom_pkg::temp_t                       power_temp,
    output logic                                  update,
    output logic signed [dbom_pkg::BOTH_W-1:0]    mean_both,
    output dbom_pkg::temp_t                       ctrl_mean,
    output dbom_pkg::temp_t                       power_mean
);
    import dbom_pkg::*;

    localparam int SUM_W     = TEMP_W + $clog2(AVG_SAMPLES);
    localparam int CNT_W     = $clog2(AVG_SAMPLES);
    localparam int DIV_SHIFT = SUM_W + $clog2(AVG_SAMPLES);
    localparam int RECIP_W   = SUM_W + 2;
    localparam int PROD_W    = SUM_W + RECIP_W;
    // rounded-up reciprocal, exact for every magnitude below 2**SUM_W
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(AVG_SAMPLES - 1);

    logic signed [SUM_W-1:0] ctrl_sum_reg, ctrl_sum_next;
    logic signed [SUM_W-1:0] power_sum_reg, power_sum_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    last;
    logic signed [SUM_W:0]   total;
    logic signed [SUM_W:0]   half;

    // signed divide by the window length, truncating toward zero
    function automatic logic signed [TEMP_W-1:0] div_avg(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [SUM_W-1:0]  q;
        logic [SUM_W-1:0]  res;
        mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        prod = PROD_W'(mag) * PROD_W'(RECIP);
        q    = SUM_W'(prod >> DIV_SHIFT);
        res  = s[SUM_W-1] ? -q : q;
        return res[TEMP_W-1:0];
    endfunction

    // sums including this word
    assign ctrl_sum_next  = ctrl_sum_reg + SUM_W'(ctrl_temp);
    assign power_sum_next = power_sum_reg + SUM_W'(power_temp);
    assign last           = (cnt_reg == CNT_LAST);

    // combined mean, floor of half the total, wrapped to the field width
    assign total = (SUM_W+1)'(ctrl_sum_next) + (SUM_W+1)'(power_sum_next);
    assign half  = total >>> 1;

    // results are zero except on the closing word of a window
    assign update     = last;
    assign mean_both  = last ? BOTH_W'(half) : '0;
    assign ctrl_mean  = last ? div_avg(ctrl_sum_next) : '0;
    assign power_mean = last ? div_avg(power_sum_next) : '0;

    // accumulators and sample counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_sum_reg  <= '0;
            power_sum_reg <= '0;
            cnt_reg       <= '0;
        end else if (step_en) begin
            if (last) begin
                ctrl_sum_reg  <= '0;
                power_sum_reg <= '0;
                cnt_reg       <= '0;
            end else begin
                ctrl_sum_reg  <= ctrl_sum_next;
                power_sum_reg <= power_sum_next;
                cnt_reg       <= cnt_reg + 1'b1;
            end
        end
    end

endmodule

>>> rtl/dual_board_overheat_monitor.sv
// Dual board overheat monitor: one word in carries a control board and a power
// board temperature sample; one word out carries two action codes and, every
// AVG_SAMPLES words, the averaged temperatures.
// Input words arrive on the s_ stream, results leave on the m_ stream. The
// thresholds, start-up window and confirm count sit in eight registers on the
// write port (cfg_wr_en, cfg_addr, cfg_wdata); write them only while idle.
// Each word is captured in an input register, worked through by the compare,
// count and accumulate logic, and held in an output register. The longest
// path is the sum-then-reciprocal-multiply for the per-board means.
// One word per cycle is sustained while m_tready stays high. When m_tready
// is low the output register holds its word, the input register still takes
// one more word, and s_tready then drops until the output moves.
// A synchronous active-low reset clears both stream stages, the start-up
// window, the board state machines, their timers and the running sums, and
// loads the registers with their reset values.
// depends on dbom_pkg, dbom_board, dbom_avg

module dual_board_overheat_monitor #(
    parameter int AVG_SAMPLES = dbom_pkg::AVG_SAMPLES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [dbom_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [dbom_pkg::CFG_W-1:0]         cfg_wdata,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dbom_pkg::S_DATA_W-1:0]      s_tdata,   // ctrl_temp, power_temp
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dbom_pkg::M_DATA_W-1:0]      m_tdata,   // ctrl_action, power_action,
                                                          // mean_both_boards, ctrl_mean,
                                                          // power_mean
    output logic                               m_tuser    // monitor_update
);
    import dbom_pkg::*;

    // configuration registers
    board_cfg_t         ctrl_cfg_reg, power_cfg_reg;
    logic [CFG_W-1:0]   startup_ticks_reg, confirm_ticks_reg;

    // stream stages
    logic               in_valid_reg;
    temp_t              in_ctrl_reg, in_power_reg;
    logic               out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic               out_user_reg;
    logic               s_accept, step_en;

    // start-up window
    logic               startup_done_reg;
    logic [TIMER_W-1:0] startup_count_reg, startup_count_next;

    // results of this word
    action_t            ctrl_action, power_action;
    logic               monitor_update;
    logic signed [BOTH_W-1:0] mean_both;
    temp_t              ctrl_mean, power_mean;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_cfg_reg      <= '{WARN_LEVEL_RST, ALARM_LEVEL_RST, CLEAR_LEVEL_RST};
            power_cfg_reg     <= '{WARN_LEVEL_RST, ALARM_LEVEL_RST, CLEAR_LEVEL_RST};
            startup_ticks_reg <= STARTUP_RST;
            confirm_ticks_reg <= CONFIRM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_CTRL_WARN:   ctrl_cfg_reg.warn_level   <= cfg_wdata;
                REG_CTRL_ALARM:  ctrl_cfg_reg.alarm_level  <= cfg_wdata;
                REG_CTRL_CLEAR:  ctrl_cfg_reg.clear_level  <= cfg_wdata;
                REG_POWER_WARN:  power_cfg_reg.warn_level  <= cfg_wdata;
                REG_POWER_ALARM: power_cfg_reg.alarm_level <= cfg_wdata;
                REG_POWER_CLEAR: power_cfg_reg.clear_level <= cfg_wdata;
                REG_STARTUP:     startup_ticks_reg         <= cfg_wdata;
                REG_CONFIRM:     confirm_ticks_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake: the word in the input register moves when the output is free
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign s_accept = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_ctrl_reg  <= s_tdata[TEMP_W-1:0];
            in_power_reg <= s_tdata[2*TEMP_W-1:TEMP_W];
        end
    end

    // start-up window counter
    assign startup_count_next = startup_count_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_done_reg  <= 1'b0;
            startup_count_reg <= '0;
        end else if (step_en && !startup_done_reg) begin
            startup_count_reg <= startup_count_next;
            if (startup_count_next > TIMER_W'(startup_ticks_reg)) begin
                startup_done_reg <= 1'b1;
            end
        end
    end

    // per board state machines
    dbom_board u_ctrl_board (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_en),
        .startup_phase (!startup_done_reg),
        .temp          (in_ctrl_reg),
        .cfg           (ctrl_cfg_reg),
        .confirm_ticks (confirm_ticks_reg),
        .action        (ctrl_action)
    );

    dbom_board u_power_board (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_en),
        .startup_phase (!startup_done_reg),
        .temp          (in_power_reg),
        .cfg           (power_cfg_reg),
        .confirm_ticks (confirm_ticks_reg),
        .action        (power_action)
    );

    // window sums and means
    dbom_avg #(
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_avg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .ctrl_temp  (in_ctrl_reg),
        .power_temp (in_power_reg),
        .update     (monitor_update),
        .mean_both  (mean_both),
        .ctrl_mean  (ctrl_mean),
        .power_mean (power_mean)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= {power_mean, ctrl_mean, mean_both, power_action, ctrl_action};
            out_user_reg <= monitor_update;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> rtl/dbom_checker.sv
// port level checks of the dual board overheat monitor, bound to the top level
// depends on dbom_pkg and dual_board_overheat_monitor

module dbom_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dbom_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);
    import dbom_pkg::*;

    // a stalled result word keeps its contents
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // means are zero unless the window closed on this word
    a_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[M_DATA_W-1:2*ACT_W] == '0)
        else $error("mean fields set without monitor update");

    // a fresh result appears once an input word taken earlier has passed the input and output registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word without matching input word");

    // two windows never close on consecutive result words
    a_update_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser |=> !(m_tvalid && m_tuser))
        else $error("monitor update on consecutive words");

endmodule

bind dual_board_overheat_monitor dbom_checker u_dbom_checker (.*);

>>> dv/testbench.sv
// self-checking bench for dual_board_overheat_monitor: directed table, then random phases
// with new thresholds each phase; results compared against an in-bench behavioral predictor
// depends on dbom_pkg and the dual_board_overheat_monitor rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dbom_pkg::*;

    localparam int AVG_N = AVG_SAMPLES_DEF;
    localparam int RANDOM_WORDS = 1600;
    localparam logic [CFG_ADDR_W-1:0] FIRST_UNUSED_REG = 8'd8;
    localparam logic [CFG_ADDR_W-1:0] TOP_UNUSED_REG   = 8'hFF;

    // one result word, split into its fields
    typedef struct packed {
        action_t                   ca;
        action_t                   pa;
        logic                      upd;
        logic signed [BOTH_W-1:0]  both;
        temp_t                     cm;
        temp_t                     pm;
    } tick_out_t;

    typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [CFG_W-1:0]       value;
        temp_t                  ctrl;
        temp_t                  power;
        bit                     typed;
        tick_out_t              want;
    } plan_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tuser;

    // predictor copy of the registers (board 0 control, board 1 power)
    logic signed [CFG_W-1:0] warn_lvl[2]  = '{WARN_LEVEL_RST, WARN_LEVEL_RST};
    logic signed [CFG_W-1:0] alarm_lvl[2] = '{ALARM_LEVEL_RST, ALARM_LEVEL_RST};
    logic signed [CFG_W-1:0] clear_lvl[2] = '{CLEAR_LEVEL_RST, CLEAR_LEVEL_RST};
    logic [CFG_W-1:0]        startup_len  = STARTUP_RST;
    logic [CFG_W-1:0]        confirm_len  = CONFIRM_RST;

    // predictor copy of the block state
    logic                      window_over = 1'b0;
    logic [TIMER_W-1:0]        window_count = '0;
    mode_t                     bmode[2] = '{MODE_NORMAL, MODE_NORMAL};
    logic [TIMER_W-1:0]        warn_tmr[2] = '{'0, '0};
    logic [TIMER_W-1:0]        alarm_tmr[2] = '{'0, '0};
    logic signed [BOTH_W-1:0]  ctrl_acc = '0;
    logic signed [BOTH_W-1:0]  power_acc = '0;
    logic [3:0]                nsamp = '0;

    tick_out_t pending_ticks[$];
    int        mismatches = 0;
    bit        tx_busy = 1'b1;
    bit        rx_busy = 1'b1;
    int        stall_left = 0;

    dual_board_overheat_monitor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // ctrl_temp, power_temp
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // ctrl_action, power_action, mean_both_boards,
                                 // ctrl_mean, power_mean
        .m_tuser   (m_tuser)     // monitor_update
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int next_gap();
        if (!tx_busy || $urandom_range(0, 2) != 0)
            return 0;
        return pause_len();
    endfunction

    // temperature a few tenths around a level, kept in range
    function automatic temp_t near(int lvl);
        int v;
        v = lvl + int'($urandom_range(0, 8)) - 4;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return temp_t'(v);
    endfunction

    // register write into the predictor copy; unknown indexes drop out
    function automatic void apply_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] v);
        case (a)
            REG_CTRL_WARN:   warn_lvl[0] = v;
            REG_CTRL_ALARM:  alarm_lvl[0] = v;
            REG_CTRL_CLEAR:  clear_lvl[0] = v;
            REG_POWER_WARN:  warn_lvl[1] = v;
            REG_POWER_ALARM: alarm_lvl[1] = v;
            REG_POWER_CLEAR: clear_lvl[1] = v;
            REG_STARTUP:     startup_len = v;
            REG_CONFIRM:     confirm_len = v;
            default: ;
        endcase
    endfunction

    // start-up window: only the clear level counts, alarm repeats while above it
    function automatic action_t startup_check(int b, temp_t t);
        if (t > clear_lvl[b]) begin
            if (alarm_tmr[b] > confirm_len) begin
                bmode[b] = MODE_ALARM;
                return ACT_ALARM;
            end
            alarm_tmr[b] = alarm_tmr[b] + 1'b1;
        end else begin
            alarm_tmr[b] = '0;
        end
        return ACT_NONE;
    endfunction

    // normal / warning / alarm machine of one board
    function automatic action_t normal_check(int b, temp_t t);
        action_t act;
        act = ACT_NONE;
        case (bmode[b])
            MODE_NORMAL: begin
                if (t > warn_lvl[b]) begin
                    if (warn_tmr[b] > confirm_len) begin
                        act = ACT_SET_WARN;
                        bmode[b] = MODE_WARN;
                    end else begin
                        warn_tmr[b] = warn_tmr[b] + 1'b1;
                    end
                end else begin
                    warn_tmr[b] = '0;
                end
            end
            MODE_WARN: begin
                if (t > alarm_lvl[b]) begin
                    if (alarm_tmr[b] > confirm_len) begin
                        act = ACT_ALARM;
                        bmode[b] = MODE_ALARM;
                    end else begin
                        alarm_tmr[b] = alarm_tmr[b] + 1'b1;
                    end
                end else if (t < warn_lvl[b]) begin
                    act = ACT_CLR_WARN;
                    bmode[b] = MODE_NORMAL;
                end else begin
                    act = ACT_SET_WARN;
                    alarm_tmr[b] = '0;
                end
            end
            MODE_ALARM: begin
                if (t > clear_lvl[b])
                    act = ACT_ALARM;
                else
                    bmode[b] = MODE_NORMAL;
            end
            default: bmode[b] = MODE_NORMAL;
        endcase
        return act;
    endfunction

    // one scan tick: averaging, then the board checks
    function automatic tick_out_t monitor_tick(temp_t c, temp_t p);
        tick_out_t r;
        int sc;
        int sp;
        r = '0;
        ctrl_acc = ctrl_acc + BOTH_W'(c);
        power_acc = power_acc + BOTH_W'(p);
        nsamp = nsamp + 1'b1;
        if (nsamp >= AVG_N) begin
            sc = int'(ctrl_acc);
            sp = int'(power_acc);
            r.upd = 1'b1;
            r.both = BOTH_W'((sc + sp) >>> 1);
            r.cm = TEMP_W'(sc / AVG_N);
            r.pm = TEMP_W'(sp / AVG_N);
            ctrl_acc = '0;
            power_acc = '0;
            nsamp = '0;
        end
        if (!window_over) begin
            r.ca = startup_check(0, c);
            r.pa = startup_check(1, p);
            window_count = window_count + 1'b1;
            if (window_count > startup_len)
                window_over = 1'b1;
        end else begin
            r.ca = normal_check(0, c);
            r.pa = normal_check(1, p);
        end
        return r;
    endfunction

    function automatic plan_row_t word_row(temp_t c, temp_t p);
        plan_row_t r;
        r.kind = ROW_WORD;
        r.ctrl = c;
        r.power = p;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t known_row(temp_t c, temp_t p, tick_out_t w);
        plan_row_t r;
        r = word_row(c, p);
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    function automatic plan_row_t write_row(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] v);
        plan_row_t r;
        r.kind = ROW_WRITE;
        r.addr = a;
        r.value = v;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s is %0d, should be %0d", $time, what, got, want);
        mismatches++;
    endtask

    // offer one word after a gap, predict its result once it is taken
    task automatic send_word(temp_t c, temp_t p, int gap, bit typed, tick_out_t want);
        tick_out_t calc;
        cfg_wr_en <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p, c};
        do @(posedge aclk); while (!s_tready);
        calc = monitor_tick(c, p);
        pending_ticks.push_back(typed ? want : calc);
    endtask

    // hold off the sender until every result is out, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_ticks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        apply_reg(a, v);
    endtask

    // result side back pressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (rx_busy && $urandom_range(0, 3) == 0) begin
            stall_left <= pause_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each taken result word with the oldest prediction
    always @(posedge aclk) begin
        tick_out_t got;
        tick_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ca = action_t'(m_tdata[1:0]);
            got.pa = action_t'(m_tdata[3:2]);
            got.upd = m_tuser;
            got.both = m_tdata[23:4];
            got.cm = m_tdata[39:24];
            got.pm = m_tdata[55:40];
            if (pending_ticks.size() == 0) begin
                report_mismatch("result word with none pending", 1, 0);
            end else begin
                want = pending_ticks.pop_front();
                if (got.ca != want.ca)
                    report_mismatch("ctrl_action", got.ca, want.ca);
                if (got.pa != want.pa)
                    report_mismatch("power_action", got.pa, want.pa);
                if (got.upd != want.upd)
                    report_mismatch("monitor_update", got.upd, want.upd);
                if (got.both != want.both)
                    report_mismatch("mean_both_boards", got.both, want.both);
                if (got.cm != want.cm)
                    report_mismatch("ctrl_mean", got.cm, want.cm);
                if (got.pm != want.pm)
                    report_mismatch("power_mean", got.pm, want.pm);
            end
        end
    end

    // run limit
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        plan_row_t plan[$];
        tick_out_t w;
        bit writing;
        int total;
        int n;
        int k;
        int base;
        int region[2];
        int dwell[2];
        temp_t t[2];
        logic signed [CFG_W-1:0] lv_warn;
        logic signed [CFG_W-1:0] lv_alarm;
        logic signed [CFG_W-1:0] lv_clear;
        logic [CFG_W-1:0] conf;
        logic [CFG_W-1:0] win;

        // start-up window at reset thresholds, hottest control and coldest power board
        w = '0;
        for (int i = 0; i < AVG_N - 1; i++)
            plan.push_back(known_row(16'sh7FFF, 16'sh8000, w));
        w.upd = 1'b1;
        w.both = -20'sd5;
        w.cm = 16'sh7FFF;
        w.pm = 16'sh8000;
        plan.push_back(known_row(16'sh7FFF, 16'sh8000, w));
        // no debounce: start-up alarm fires and repeats, writes past the last register drop
        plan.push_back(write_row(REG_CONFIRM, 16'd0));
        plan.push_back(write_row(FIRST_UNUSED_REG, 16'h1234));
        plan.push_back(write_row(TOP_UNUSED_REG, 16'h8000));
        plan.push_back(word_row(16'sd851, 16'sd851));
        plan.push_back(word_row(16'sd851, 16'sd851));
        plan.push_back(word_row(16'sd850, -16'sd1));
        // close the window, alarm falls back to normal
        plan.push_back(write_row(REG_STARTUP, 16'd0));
        plan.push_back(word_row(16'sd0, 16'sd0));
        plan.push_back(word_row(16'sd0, 16'sd0));
        // warning, hold, alarm, clear, and a warning at once with the kept timer
        plan.push_back(write_row(REG_CTRL_WARN, 16'd100));
        plan.push_back(write_row(REG_CTRL_ALARM, 16'd200));
        plan.push_back(write_row(REG_CTRL_CLEAR, 16'd50));
        plan.push_back(write_row(REG_POWER_WARN, -16'sd100));
        plan.push_back(write_row(REG_POWER_ALARM, -16'sd50));
        plan.push_back(write_row(REG_POWER_CLEAR, -16'sd200));
        plan.push_back(word_row(16'sd101, -16'sd99));
        plan.push_back(word_row(16'sd101, -16'sd99));
        plan.push_back(word_row(16'sd100, -16'sd100));
        plan.push_back(word_row(16'sd201, -16'sd49));
        plan.push_back(word_row(16'sd201, -16'sd49));
        plan.push_back(word_row(16'sd51, -16'sd199));
        plan.push_back(word_row(16'sd50, -16'sd200));
        plan.push_back(word_row(16'sd101, -16'sd99));
        plan.push_back(word_row(16'sd99, -16'sd101));
        plan.push_back(word_row(16'sd101, -16'sd99));

        // reset once
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        writing = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (!writing)
                    wait_idle();
                writing = 1'b1;
                write_reg(plan[i].addr, plan[i].value);
            end else begin
                writing = 1'b0;
                send_word(plan[i].ctrl, plan[i].power, next_gap(), plan[i].typed,
                          plan[i].want);
            end
        end

        // random phases, each with fresh thresholds and pacing
        total = 0;
        dwell = '{0, 0};
        region = '{0, 0};
        while (total < RANDOM_WORDS) begin
            wait_idle();
            for (int b = 0; b < 2; b++) begin
                k = $urandom_range(0, 7);
                if (k == 0) begin
                    lv_clear = CFG_W'($urandom);
                    lv_warn = CFG_W'($urandom);
                    lv_alarm = CFG_W'($urandom);
                end else if (k == 1) begin
                    lv_clear = 16'sh8000;
                    lv_warn = 16'sh8000;
                    lv_alarm = 16'sh7FFF;
                end else if (k == 2) begin
                    lv_clear = 16'sh7FFF;
                    lv_warn = 16'sh7FFF;
                    lv_alarm = 16'sh7FFF;
                end else begin
                    base = int'($urandom_range(0, 4000)) - 2000;
                    lv_clear = CFG_W'(base);
                    lv_warn = CFG_W'(base + int'($urandom_range(0, 80)));
                    lv_alarm = CFG_W'(int'(lv_warn) + int'($urandom_range(0, 80)));
                end
                write_reg(b == 0 ? REG_CTRL_WARN : REG_POWER_WARN, lv_warn);
                write_reg(b == 0 ? REG_CTRL_ALARM : REG_POWER_ALARM, lv_alarm);
                write_reg(b == 0 ? REG_CTRL_CLEAR : REG_POWER_CLEAR, lv_clear);
            end
            case ($urandom_range(0, 2))
                0: win = 16'd0;
                1: win = 16'hFFFF;
                default: win = CFG_W'($urandom);
            endcase
            write_reg(REG_STARTUP, win);
            case ($urandom_range(0, 9))
                0: conf = 16'd0;
                1: conf = 16'hFFFF;
                2: conf = CFG_W'($urandom);
                default: conf = CFG_W'($urandom_range(1, 6));
            endcase
            write_reg(REG_CONFIRM, conf);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_ADDR_W'($urandom_range(FIRST_UNUSED_REG, TOP_UNUSED_REG)),
                          CFG_W'($urandom));
            tx_busy = ($urandom_range(0, 3) != 0);
            rx_busy = ($urandom_range(0, 3) != 0);

            // dwell near one threshold for a while, with some noise mixed in
            n = $urandom_range(60, 140);
            repeat (n) begin
                for (int b = 0; b < 2; b++) begin
                    if (dwell[b] == 0) begin
                        region[b] = $urandom_range(0, 2);
                        dwell[b] = $urandom_range(1, 14);
                    end
                    dwell[b]--;
                    if ($urandom_range(0, 9) == 0)
                        t[b] = temp_t'($urandom);
                    else if (region[b] == 0)
                        t[b] = near(int'(clear_lvl[b]));
                    else if (region[b] == 1)
                        t[b] = near(int'(warn_lvl[b]));
                    else
                        t[b] = near(int'(alarm_lvl[b]));
                end
                send_word(t[0], t[1], next_gap(), 1'b0, '0);
                total++;
            end
        end

        // drain and settle
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
